@@ rtl/core/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// pls_pkg: shared types and codes of the positional list store
// Operation and status codes, transaction structs and the cell control bundle.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int IDX_W = 10;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_READ      = 3'd6;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         entry_count;
		logic signed [31:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic             rd;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

@@ rtl/core/pls_cell.sv @@
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list
// Holds one entry and moves it toward its upper or lower neighbor.
// ----------------------------------------------------------------------------
module pls_cell #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  pls_pkg::cell_ctl_t      ctl,
	input  logic signed [31:0]      value,
	input  logic signed [31:0]      lower,
	input  logic signed [31:0]      upper,
	output logic signed [31:0]      data,
	output logic signed [31:0]      hit
);
	import pls_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && MY_IDX > ctl.idx) begin
			data_q <= lower;
		end else if (ctl.ins && MY_IDX == ctl.idx) begin
			data_q <= value;
		end else if (ctl.del && MY_IDX >= ctl.idx) begin
			data_q <= upper;
		end
	end

	assign data = data_q;
	assign hit  = (ctl.rd && MY_IDX == ctl.idx) ? data_q : '0;

endmodule

@@ rtl/core/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store: ordered list with insert, delete and read by position
// Holds up to CAPACITY signed 32-bit entries in a row of shifting cells.
// ----------------------------------------------------------------------------
// A request transaction on req carries an operation, a value and a 1-based
// position. Every request produces exactly one response transaction on rsp,
// giving a status, the entry count after the operation and, for a read, the
// value found at the position.
// The block works on one request at a time. A request is taken in the idle
// state; the next cycle carries out the shift in all cells at once and
// captures the read data in groups of eight cells; the cycle after that
// merges the groups into the response register. The response is visible
// once the merge step loads that register, and req_ready returns in the
// same cycle, so a new request is taken only once the last one is loaded.
// If rsp_ready stays low, the response register holds its transaction and a
// following request waits in the merge step until the register frees up.
// Reset empties the list at once; the cell contents are not cleared and
// are never shown before they are written.
// ----------------------------------------------------------------------------
module positional_list_store #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  pls_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pls_pkg::rsp_t  rsp
);
	import pls_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 7) ? CW : 7) + 1;
	localparam int NG = (CAPACITY + 7) / 8;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MERGE = 2'd2;

	logic [1:0]         state_q;
	req_t               cmd_q;
	logic [CW-1:0]      count_q;
	logic [1:0]         status_q;
	logic signed [31:0] grp_q [NG];
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [XW-1:0]      cnt_x;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      idx_x;
	logic               ins_ok;
	logic               del_ok;
	logic               rd_ok;
	logic [1:0]         status_c;
	cell_ctl_t          ctl;
	logic signed [31:0] data_w [CAPACITY];
	logic signed [31:0] hit_w [NG*8];
	logic signed [31:0] rd_c;
	logic               rsp_load;

	always_comb begin
		cnt_x    = XW'(count_q);
		pos_x    = XW'(cmd_q.position);
		idx_x    = '0;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		rd_ok    = 1'b0;
		status_c = ST_INVALID;
		case (cmd_q.op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
				if (cnt_x == XW'(CAPACITY)) begin
					status_c = ST_FULL;
				end else if (cmd_q.op == OP_INS_FRONT) begin
					ins_ok = 1'b1;
				end else if (cmd_q.op == OP_INS_BACK) begin
					ins_ok = 1'b1;
					idx_x  = cnt_x;
				end else if (pos_x != '0 && pos_x <= cnt_x + XW'(1)) begin
					ins_ok = 1'b1;
					idx_x  = pos_x - XW'(1);
				end
			end
			OP_DEL_FRONT: begin
				del_ok = (cnt_x != '0);
			end
			OP_DEL_BACK: begin
				del_ok = (cnt_x != '0);
				idx_x  = cnt_x - XW'(1);
			end
			OP_DEL_POS: begin
				del_ok = (pos_x != '0 && pos_x <= cnt_x);
				idx_x  = pos_x - XW'(1);
			end
			OP_READ: begin
				rd_ok = (pos_x != '0 && pos_x <= cnt_x);
				idx_x = pos_x - XW'(1);
			end
			default: begin
				idx_x = '0;
			end
		endcase
		if (ins_ok || del_ok || rd_ok) begin
			status_c = ST_DONE;
		end
		ctl.ins = (state_q == S_EXEC) && ins_ok;
		ctl.del = (state_q == S_EXEC) && del_ok;
		ctl.rd  = (state_q == S_EXEC) && rd_ok;
		ctl.idx = IDX_W'(idx_x);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] lower_w;
		logic signed [31:0] upper_w;
		if (i == 0) begin : g_first
			assign lower_w = cmd_q.value;
		end else begin : g_inner_lo
			assign lower_w = data_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_w = data_w[i];
		end else begin : g_inner_hi
			assign upper_w = data_w[i+1];
		end
		pls_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (cmd_q.value),
			.lower (lower_w),
			.upper (upper_w),
			.data  (data_w[i]),
			.hit   (hit_w[i])
		);
	end

	for (genvar i = CAPACITY; i < NG*8; i++) begin : g_pad
		assign hit_w[i] = '0;
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic signed [31:0] acc;
		always_comb begin
			acc = '0;
			for (int j = 0; j < 8; j++) begin
				acc = acc | hit_w[g*8+j];
			end
		end
		always_ff @(posedge clk) begin
			if (state_q == S_EXEC) begin
				grp_q[g] <= acc;
			end
		end
	end

	always_comb begin
		rd_c = '0;
		for (int g = 0; g < NG; g++) begin
			rd_c = rd_c | grp_q[g];
		end
	end

	assign rsp_load = (state_q == S_MERGE) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ins_ok) begin
						count_q <= count_q + CW'(1);
					end else if (del_ok) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= req;
		end
		if (state_q == S_EXEC) begin
			status_q <= status_c;
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= 7'(count_q);
			rsp_q.read_value  <= rd_c;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/pls_checker.sv @@
// ----------------------------------------------------------------------------
// pls_checker: port checks for the positional list store
// Watches the request handshake, the response channel and the response contents over time.
// ----------------------------------------------------------------------------
module pls_checker #(
	parameter int CAPACITY = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input pls_pkg::rsp_t rsp
);
	import pls_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Response changed while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_DONE || rsp.status == ST_INVALID
			|| rsp.status == ST_FULL)
		else $error("Response status code has no meaning.");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_DONE |-> rsp.read_value == '0)
		else $error("Read value is nonzero on a rejected transaction.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == 7'(CAPACITY))
		else $error("Store reported full below capacity.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Second request taken while one is in progress.");

endmodule

bind positional_list_store pls_checker #(
	.CAPACITY(CAPACITY)
) u_pls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
